[design/skc_pkg.sv]
// ----------------------------------------------------------------------------
// skc_pkg
// Shared types and constants for the stretched-key XOR cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package skc_pkg;

   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned PosWidth     = 5;
   localparam int unsigned LenWidth     = 6;
   localparam int unsigned CsrIdxWidth  = 3;
   localparam int unsigned CsrDataWidth = 64;
   localparam int unsigned MaxPassword  = 32;
   localparam int unsigned RotateLeft   = 3;

   // register map
   typedef enum logic [CsrIdxWidth-1:0] {
      REG_PW_LOW    = 3'd0,
      REG_PW_SECOND = 3'd1,
      REG_PW_THIRD  = 3'd2,
      REG_PW_HIGH   = 3'd3,
      REG_PW_LENGTH = 3'd4
   } csr_reg_type;

   // one beat moving down the chain of rounds
   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic [ByteWidth-1:0] data;
      logic [ByteWidth-1:0] value;
   } round_beat_type;

   function automatic logic [ByteWidth-1:0] rotl3(input logic [ByteWidth-1:0] v);
      return {v[ByteWidth-1-RotateLeft:0], v[ByteWidth-1:ByteWidth-RotateLeft]};
   endfunction

endpackage

`default_nettype wire

[design/skc_cell.sv]
// ----------------------------------------------------------------------------
// skc_cell
// One round of key stretching: holds its carry, mixes the passing value.
// ----------------------------------------------------------------------------
`default_nettype none

module skc_cell #(
   parameter int unsigned STAGE = 0
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire skc_pkg::round_beat_type beat_in,
   output skc_pkg::round_beat_type      beat_out
);

   localparam logic [skc_pkg::ByteWidth-1:0] CarryInit = 8'(STAGE % 256);

   logic [skc_pkg::ByteWidth-1:0] carry_ff;
   logic [skc_pkg::ByteWidth-1:0] carry_in;
   logic [skc_pkg::ByteWidth-1:0] mixed;
   logic                          valid_ff;
   logic                          valid_in;
   skc_pkg::round_beat_type       beat_ff;
   skc_pkg::round_beat_type       beat_in_next;

   assign mixed = skc_pkg::rotl3(beat_in.value ^ carry_ff);

   always_comb begin
      carry_in = carry_ff;
      valid_in = valid_ff;
      beat_in_next = beat_ff;
      if (advance) begin
         valid_in = beat_in.valid;
         beat_in_next.valid = beat_in.valid;
         beat_in_next.last  = beat_in.last;
         beat_in_next.data  = beat_in.data;
         beat_in_next.value = mixed;
         if (beat_in.valid) begin
            // end of message puts this round back to its initial carry
            carry_in = beat_in.last ? CarryInit : mixed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= CarryInit;
         valid_ff <= 1'b0;
      end else begin
         carry_ff <= carry_in;
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in_next;
   end

   always_comb begin
      beat_out = beat_ff;
      beat_out.valid = valid_ff;
   end

endmodule

`default_nettype wire

[design/skc_seed.sv]
// ----------------------------------------------------------------------------
// skc_seed
// Password registers, key position and seed byte selection.
// ----------------------------------------------------------------------------
`default_nettype none

module skc_seed (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   input  wire logic [skc_pkg::CsrIdxWidth-1:0]     csr_index,
   input  wire logic [skc_pkg::CsrDataWidth-1:0]    csr_data,
   input  wire logic                                step,
   input  wire logic                                step_last,
   output logic      [skc_pkg::ByteWidth-1:0]       seed
);

   logic [3:0][skc_pkg::CsrDataWidth-1:0] pw_ff;
   logic [3:0][skc_pkg::CsrDataWidth-1:0] pw_in;
   logic [skc_pkg::LenWidth-1:0]          len_ff;
   logic [skc_pkg::LenWidth-1:0]          len_in;
   logic [skc_pkg::LenWidth-1:0]          active_len;
   logic [skc_pkg::PosWidth-1:0]          pos_ff;
   logic [skc_pkg::PosWidth-1:0]          pos_in;
   logic [skc_pkg::LenWidth-1:0]          pos_next;
   logic [skc_pkg::CsrDataWidth-1:0]      word;

   always_comb begin
      pw_in  = pw_ff;
      len_in = len_ff;
      if (csr_valid) begin
         case (skc_pkg::csr_reg_type'(csr_index))
            skc_pkg::REG_PW_LOW:    pw_in[0] = csr_data;
            skc_pkg::REG_PW_SECOND: pw_in[1] = csr_data;
            skc_pkg::REG_PW_THIRD:  pw_in[2] = csr_data;
            skc_pkg::REG_PW_HIGH:   pw_in[3] = csr_data;
            skc_pkg::REG_PW_LENGTH: len_in = csr_data[skc_pkg::LenWidth-1:0];
            default: ;
         endcase
      end
   end

   // zero length means one byte, anything above the maximum saturates
   always_comb begin
      if (len_ff == '0) begin
         active_len = skc_pkg::LenWidth'(1);
      end else if (len_ff > skc_pkg::LenWidth'(skc_pkg::MaxPassword)) begin
         active_len = skc_pkg::LenWidth'(skc_pkg::MaxPassword);
      end else begin
         active_len = len_ff;
      end
   end

   assign pos_next = {1'b0, pos_ff} + skc_pkg::LenWidth'(1);

   always_comb begin
      pos_in = pos_ff;
      if (step) begin
         if (step_last || pos_next >= active_len) begin
            pos_in = '0;
         end else begin
            pos_in = pos_next[skc_pkg::PosWidth-1:0];
         end
      end
   end

   assign word = pw_ff[pos_ff[4:3]];
   assign seed = word[{pos_ff[2:0], 3'b000} +: skc_pkg::ByteWidth];

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_ff  <= '0;
         len_ff <= skc_pkg::LenWidth'(1);
         pos_ff <= '0;
      end else begin
         pw_ff  <= pw_in;
         len_ff <= len_in;
         pos_ff <= pos_in;
      end
   end

endmodule

`default_nettype wire

[design/stretched_key_xor_cipher_top.sv]
// ----------------------------------------------------------------------------
// stretched_key_xor_cipher_top
// Byte stream cipher: each byte XORed with a key byte stretched over ROUNDS.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one message byte per beat, req_tlast marks its final byte.
//   rsp_ returns one beat per request beat, in order: tdata = byte XOR key,
//   tlast copies the request's tlast. The same stream decrypts.
//   csr_ writes the password bytes (index 0..3, 64 bits each, byte k at bits
//   8k) and the password length (index 4); write only while the block is idle.
// Timing:
//   The key byte runs through a chain of ROUNDS registered cells, each
//   cell keeping its own carry, then through the response register. A new
//   byte can enter every cycle while the chain is not stalled, so throughput
//   is one byte per cycle.
// Reset and stall:
//   Reset empties the chain, returns every carry to its initial value, the
//   key position to zero, the password to zero and the length to one.
//   After a tlast beat the carries and position restart for the next message.
//   When rsp_tready is low with a response waiting, the whole chain holds
//   and req_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module stretched_key_xor_cipher_top #(
   parameter int unsigned ROUNDS = 1000
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: tdata = data_byte[7:0]; tlast = end_of_message
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tlast,
   // response: tdata = result_byte[7:0]; tlast = final_flag
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [7:0]  rsp_tdata,
   output logic             rsp_tlast,
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   logic                          advance;
   logic [skc_pkg::ByteWidth-1:0] seed;
   skc_pkg::round_beat_type       chain [ROUNDS+1];

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [skc_pkg::ByteWidth-1:0] rsp_data_ff;
   logic [skc_pkg::ByteWidth-1:0] rsp_data_in;
   logic                          rsp_last_ff;
   logic                          rsp_last_in;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;

   skc_seed u_seed (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .step      (req_tvalid && advance),
      .step_last (req_tlast),
      .seed      (seed)
   );

   assign chain[0] = '{valid: req_tvalid, last: req_tlast, data: req_tdata, value: seed};

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      skc_cell #(
         .STAGE (r)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .beat_in  (chain[r]),
         .beat_out (chain[r+1])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = chain[ROUNDS].valid;
         rsp_data_in  = chain[ROUNDS].data ^ chain[ROUNDS].value;
         rsp_last_in  = chain[ROUNDS].last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
